>>> src/btpm_pkg.sv
package btpm_pkg;

   localparam int ADDR_PORT_W = 32;
   localparam int LEN_PORT_W  = 6;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EVAL,
      ST_ALLOC,
      ST_READ,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic load;       // capture item, read root
      logic read_node;  // read current node
      logic eval;       // lookup: record best match if node is a prefix end
      logic advance;    // step to existing child and read it
      logic mark;       // write current node with prefix-end set
      logic link;       // write current node with new child pointer
      logic alloc;      // clear new node and step into it
      logic set_full;   // pool exhausted
      logic finish;     // load result register
   } cmd_type;

   typedef struct packed {
      logic is_insert;
      logic at_end;
      logic child_zero;
      logic pool_empty;
      logic out_busy;
   } status_type;

endpackage

>>> src/btpm_ram.sv
module btpm_ram #(
   parameter int WIDTH = 21,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> src/btpm_ctrl.sv
module btpm_ctrl import btpm_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  status_type stat,
   output cmd_type    cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            if (stat.is_insert) begin
               if (stat.at_end) begin
                  cmd.mark = 1'b1;
                  state_in = ST_DONE;
               end else if (!stat.child_zero) begin
                  cmd.advance = 1'b1;
               end else if (stat.pool_empty) begin
                  cmd.set_full = 1'b1;
                  state_in     = ST_DONE;
               end else begin
                  cmd.link = 1'b1;
                  state_in = ST_ALLOC;
               end
            end else begin
               cmd.eval = 1'b1;
               if (stat.at_end || stat.child_zero) begin
                  state_in = ST_DONE;
               end else begin
                  cmd.advance = 1'b1;
               end
            end
         end
         ST_ALLOC: begin
            cmd.alloc = 1'b1;
            state_in  = ST_READ;
         end
         ST_READ: begin
            cmd.read_node = 1'b1;
            state_in      = ST_EVAL;
         end
         ST_DONE: begin
            // hold until the result register is free
            if (!stat.out_busy) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

>>> src/btpm_dp.sv
module btpm_dp import btpm_pkg::*; #(
   parameter int NODE_COUNT   = 1024,
   parameter int ADDRESS_BITS = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_mode,
   input  logic [ADDR_PORT_W-1:0] req_address,
   input  logic [LEN_PORT_W-1:0]  req_prefix_length,
   input  cmd_type                cmd,
   output status_type             stat,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [ADDR_PORT_W-1:0] rsp_matched_prefix,
   output logic [LEN_PORT_W-1:0]  rsp_matched_length,
   output logic                   rsp_table_full
);

   localparam int PTR_W   = $clog2(NODE_COUNT);
   localparam int CNT_W   = PTR_W + 1;
   localparam int LEN_W   = $clog2(ADDRESS_BITS + 1);
   localparam int ENTRY_W = 2 * PTR_W + 1;
   localparam int END_BIT = ENTRY_W - 1;
   localparam logic [ADDRESS_BITS-1:0] ADDR_MSB = {1'b1, {(ADDRESS_BITS-1){1'b0}}};

   logic                    mode_ff, mode_in;
   logic [ADDRESS_BITS-1:0] addr_ff, addr_in;
   logic [LEN_W-1:0]        len_ff, len_in;
   logic [LEN_W-1:0]        level_ff, level_in;
   logic [PTR_W-1:0]        node_ff, node_in;
   logic [ADDRESS_BITS-1:0] path_ff, path_in;
   logic [ADDRESS_BITS-1:0] best_ff, best_in;
   logic [LEN_W-1:0]        best_len_ff, best_len_in;
   logic                    full_ff, full_in;
   logic [CNT_W-1:0]        free_ff, free_in;
   logic                    root_valid_ff, root_valid_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [ADDR_PORT_W-1:0]  rsp_prefix_ff, rsp_prefix_in;
   logic [LEN_PORT_W-1:0]   rsp_length_ff, rsp_length_in;
   logic                    rsp_full_ff, rsp_full_in;

   logic [ENTRY_W-1:0]      rd_data;
   logic [ENTRY_W-1:0]      entry;
   logic [ADDRESS_BITS-1:0] addr_sh;
   logic                    cur_bit;
   logic [PTR_W-1:0]        child;
   logic [PTR_W-1:0]        free_ptr;
   logic [ADDRESS_BITS-1:0] path_step;
   logic [ENTRY_W-1:0]      link_data;
   logic                    wr_en;
   logic [PTR_W-1:0]        wr_addr;
   logic [ENTRY_W-1:0]      wr_data;
   logic                    rd_en;
   logic [PTR_W-1:0]        rd_addr;

   // root reads as empty until first written
   assign entry    = (node_ff == '0 && !root_valid_ff) ? '0 : rd_data;
   assign addr_sh  = addr_ff << level_ff;
   assign cur_bit  = addr_sh[ADDRESS_BITS-1];
   assign child    = cur_bit ? entry[2*PTR_W-1:PTR_W] : entry[PTR_W-1:0];
   assign free_ptr = free_ff[PTR_W-1:0];
   assign path_step = cur_bit ? (path_ff | (ADDR_MSB >> level_ff)) : path_ff;
   assign link_data = cur_bit ? {entry[END_BIT], free_ptr, entry[PTR_W-1:0]}
                              : {entry[END_BIT], entry[2*PTR_W-1:PTR_W], free_ptr};

   assign wr_en   = cmd.mark | cmd.link | cmd.alloc;
   assign wr_addr = cmd.alloc ? free_ptr : node_ff;
   assign wr_data = cmd.alloc ? '0
                  : cmd.mark  ? {1'b1, entry[2*PTR_W-1:0]}
                  : link_data;
   assign rd_en   = cmd.load | cmd.read_node | cmd.advance;
   assign rd_addr = cmd.load ? '0 : (cmd.advance ? child : node_ff);

   btpm_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (NODE_COUNT)
   ) u_node_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign stat.is_insert  = mode_ff;
   assign stat.at_end     = (level_ff == len_ff);
   assign stat.child_zero = (child == '0);
   assign stat.pool_empty = (free_ff >= CNT_W'(NODE_COUNT));
   assign stat.out_busy   = rsp_valid_ff && !rsp_ready;

   always_comb begin
      mode_in       = mode_ff;
      addr_in       = addr_ff;
      len_in        = len_ff;
      level_in      = level_ff;
      node_in       = node_ff;
      path_in       = path_ff;
      best_in       = best_ff;
      best_len_in   = best_len_ff;
      full_in       = full_ff;
      free_in       = free_ff;
      root_valid_in = root_valid_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_prefix_in = rsp_prefix_ff;
      rsp_length_in = rsp_length_ff;
      rsp_full_in   = rsp_full_ff;

      if (cmd.load) begin
         mode_in     = req_mode;
         addr_in     = req_address[ADDRESS_BITS-1:0];
         // clamp length to the address width
         if (req_prefix_length > LEN_PORT_W'(ADDRESS_BITS)) begin
            len_in = LEN_W'(ADDRESS_BITS);
         end else begin
            len_in = LEN_W'(req_prefix_length);
         end
         level_in    = '0;
         node_in     = '0;
         path_in     = '0;
         best_in     = '0;
         best_len_in = '0;
         full_in     = 1'b0;
      end

      if (cmd.eval && entry[END_BIT]) begin
         best_in     = path_ff;
         best_len_in = level_ff;
      end

      if (cmd.advance) begin
         node_in  = child;
         level_in = level_ff + LEN_W'(1);
         path_in  = path_step;
      end

      if (cmd.alloc) begin
         node_in  = free_ptr;
         free_in  = free_ff + CNT_W'(1);
         level_in = level_ff + LEN_W'(1);
         path_in  = path_step;
      end

      if ((cmd.mark || cmd.link) && node_ff == '0) begin
         root_valid_in = 1'b1;
      end

      if (cmd.set_full) begin
         full_in = 1'b1;
      end

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      if (cmd.finish) begin
         rsp_valid_in  = 1'b1;
         rsp_prefix_in = ADDR_PORT_W'(best_ff);
         rsp_length_in = LEN_PORT_W'(best_len_ff);
         rsp_full_in   = full_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         free_ff       <= CNT_W'(1);
         root_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         free_ff       <= free_in;
         root_valid_ff <= root_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff       <= mode_in;
      addr_ff       <= addr_in;
      len_ff        <= len_in;
      level_ff      <= level_in;
      node_ff       <= node_in;
      path_ff       <= path_in;
      best_ff       <= best_in;
      best_len_ff   <= best_len_in;
      full_ff       <= full_in;
      rsp_prefix_ff <= rsp_prefix_in;
      rsp_length_ff <= rsp_length_in;
      rsp_full_ff   <= rsp_full_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_matched_prefix = rsp_prefix_ff;
   assign rsp_matched_length = rsp_length_ff;
   assign rsp_table_full     = rsp_full_ff;

endmodule

>>> src/binary_trie_prefix_match.sv
// channel   handshake               payload
// req       req_valid / req_ready   req_mode, req_address, req_prefix_length
// rsp       rsp_valid / rsp_ready   rsp_matched_prefix, rsp_matched_length,
//                                   rsp_table_full
//
// One item at a time; the walk reads one trie node per cycle from the node RAM while it
// steps through existing nodes. Lookup walks at most prefix_length levels (clamped to
// ADDRESS_BITS), fewer when the walk leaves the trie. Insert walks the same way and, for
// each node allocated, writes the new node and re-reads it.
// Reset: no nodes allocated, root reads as cleared; nodes need no clearing pass.
// A result waiting in the output register holds the controller only at the end
// of the next item.
module binary_trie_prefix_match import btpm_pkg::*; #(
   parameter int NODE_COUNT   = 1024,
   parameter int ADDRESS_BITS = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic                   req_mode,
   input  logic [ADDR_PORT_W-1:0] req_address,
   input  logic [LEN_PORT_W-1:0]  req_prefix_length,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [ADDR_PORT_W-1:0] rsp_matched_prefix,
   output logic [LEN_PORT_W-1:0]  rsp_matched_length,
   output logic                   rsp_table_full
);

   cmd_type    cmd;
   status_type stat;

   btpm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   btpm_dp #(
      .NODE_COUNT   (NODE_COUNT),
      .ADDRESS_BITS (ADDRESS_BITS)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .req_mode           (req_mode),
      .req_address        (req_address),
      .req_prefix_length  (req_prefix_length),
      .cmd                (cmd),
      .stat               (stat),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_matched_prefix (rsp_matched_prefix),
      .rsp_matched_length (rsp_matched_length),
      .rsp_table_full     (rsp_table_full)
   );

endmodule
